// ===== hdl/eucm_pkg.sv =====
// ----------------------------------------------------------------------------
// EUCM keypoint unprojection package
// Shared constants, pipeline payload types and fixed-point helpers.
// ----------------------------------------------------------------------------
package eucm_pkg;

  localparam int SQ_CELLS = 28;
  localparam int DV_CELLS = 24;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_INV_FOCAL_X = 3'd2,
    REG_INV_FOCAL_Y = 3'd3,
    REG_MODEL_ALPHA = 3'd4,
    REG_MODEL_BETA  = 3'd5
  } reg_index_t;

  localparam logic [19:0] BETA_RESET = 20'd65536;
  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = -24'sh800000;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               fallback;
    logic               sat;
    logic               off;
    logic               last;
  } side_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [55:0] num;
    logic [55:0]        rad;
    logic [29:0]        rem;
    logic [27:0]        root;
  } sq_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic        neg;
    logic        dz;
    logic        ov;
    logic        num_neg;
    logic [31:0] rem;
    logic [23:0] nlo;
    logic [23:0] quo;
    logic [31:0] dd;
  } dv_t;

  // Rounds v / 2^12 to nearest (ties away from zero) and saturates to 24 bits.
  // Bit 24 of the result is the saturation flag.
  function automatic logic [24:0] sat_round12(input logic signed [41:0] v);
    logic [41:0] m;
    logic [29:0] r;
    logic [24:0] res;
    m = v[41] ? 42'(-v) : 42'(v);
    r = 30'((m + 42'd2048) >> 12);
    if (!v[41] && r > 30'd8388607) begin
      res = {1'b1, S24_MAX};
    end else if (v[41] && r > 30'd8388608) begin
      res = {1'b1, S24_MIN};
    end else if (v[41]) begin
      res = {1'b0, 24'(-$signed({1'b0, r}))};
    end else begin
      res = {1'b0, r[23:0]};
    end
    return res;
  endfunction

endpackage

// ===== hdl/eucm_keypoint_unprojection_top.sv =====
// ----------------------------------------------------------------------------
// EUCM keypoint unprojection top level
// Lifts Q12.4 keypoints to Q8.16 rays through a pipeline of square-root and
// divider cells.
// A keypoint passes from input transfer to result through six front stages,
// 28 square-root cells, three denominator stages, 24 divider cells and the
// output register. One keypoint is accepted every cycle while no stall holds.
// Synchronous reset empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module eucm_keypoint_unprojection_top
  import eucm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        pixel_x,
  input  logic [15:0]        pixel_y,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] ray_x,
  output logic signed [23:0] ray_y,
  output logic signed [23:0] ray_z,
  output logic               used_fallback,
  output logic               saturated,
  output logic               distortion_off,
  output logic               last_out
);

  logic [15:0] center_x, center_y;
  logic [23:0] inv_focal_x, inv_focal_y;
  logic [16:0] model_alpha;
  logic [19:0] model_beta;

  logic [33:0]        aa;
  logic [22:0]        ba2;
  logic signed [23:0] cc;
  logic signed [39:0] cprod;
  logic [53:0]        baa;
  logic [39:0]        cmag;

  logic en;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      inv_focal_x <= '0;
      inv_focal_y <= '0;
      model_alpha <= '0;
      model_beta  <= BETA_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:    center_x    <= cfg_data[15:0];
        REG_CENTER_Y:    center_y    <= cfg_data[15:0];
        REG_INV_FOCAL_X: inv_focal_x <= cfg_data;
        REG_INV_FOCAL_Y: inv_focal_y <= cfg_data;
        REG_MODEL_ALPHA: model_alpha <= cfg_data[16:0];
        REG_MODEL_BETA:  model_beta  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Derived model constants are registered from the registers: aa and cc directly, ba2 through aa.
  assign baa   = 54'(model_beta * aa);
  assign cprod = 40'($signed({1'b0, model_alpha, 1'b0}) - 19'sd65536) * $signed({1'b0, model_beta});
  assign cmag  = cprod[39] ? 40'(-cprod) : 40'(cprod);

  always_ff @(posedge clk) begin
    aa  <= 34'(model_alpha * model_alpha);
    ba2 <= 23'((baa + 54'h80000000) >> 32);
    cc  <= cprod[39] ? -$signed(24'((cmag + 40'd32768) >> 16))
                     : $signed(24'((cmag + 40'd32768) >> 16));
  end

  // Front stages.
  logic v1, v2, v3, v4, v5;
  side_t sd1, sd2, sd3, sd4, sd5;
  logic signed [41:0] mx1, my1;
  logic [24:0] rx, ry;
  logic [47:0] xx3, yy3;
  logic [31:0] r2q4;
  logic [54:0] pa5;
  logic signed [56:0] pc5;
  logic signed [56:0] s6;
  logic signed [55:0] num6;
  logic [23:0] ax, ay;
  sq_t sq_in;

  assign rx   = sat_round12(mx1);
  assign ry   = sat_round12(my1);
  assign ax   = sd2.x[23] ? 24'(-sd2.x) : 24'(sd2.x);
  assign ay   = sd2.y[23] ? 24'(-sd2.y) : 24'(sd2.y);
  assign s6   = 57'sh100000000 - pc5;
  assign num6 = 56'sh100000000 - $signed({1'b0, pa5});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      sq_in.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;

      mx1 <= 42'(($signed({1'b0, pixel_x}) - $signed({1'b0, center_x}))
                 * $signed({1'b0, inv_focal_x}));
      my1 <= 42'(($signed({1'b0, pixel_y}) - $signed({1'b0, center_y}))
                 * $signed({1'b0, inv_focal_y}));
      sd1 <= '{x: '0, y: '0, fallback: 1'b0, sat: 1'b0,
               off: (model_alpha == '0), last: is_last};

      sd2 <= '{x: $signed(rx[23:0]), y: $signed(ry[23:0]), fallback: sd1.fallback,
               sat: rx[24] | ry[24], off: sd1.off, last: sd1.last};

      sd3 <= sd2;
      xx3 <= ax * ax;
      yy3 <= ay * ay;

      sd4  <= sd3;
      r2q4 <= 32'(({1'b0, xx3} + {1'b0, yy3} + 49'd32768) >> 16);

      sd5 <= sd4;
      pa5 <= 55'(ba2 * r2q4);
      pc5 <= 57'(cc * $signed({1'b0, r2q4}));

      sq_in <= '{valid: v5,
                 side: '{x: sd5.x, y: sd5.y, fallback: s6[56], sat: sd5.sat,
                         off: sd5.off, last: sd5.last},
                 num: num6,
                 rad: s6[56] ? 56'd0 : s6[55:0],
                 rem: 30'd0,
                 root: 28'd0};
    end
  end

  // Square-root cell row.
  sq_t sq [SQ_CELLS+1];
  assign sq[0] = sq_in;

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
    eucm_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (sq[i]),
      .q   (sq[i+1])
    );
  end

  // Denominator stages.
  logic v7, v8;
  side_t sd7, sd8;
  logic signed [55:0] num7;
  logic [44:0] aq7;
  logic [29:0] rq;
  logic signed [31:0] den;
  logic [55:0] nm;
  logic [30:0] dm;
  logic [57:0] n8;
  logic [31:0] d8;
  logic dz8, neg8, nneg8;
  dv_t dv_in;
  logic ov9;

  assign rq  = 30'((aq7 + 45'd32768) >> 16);
  assign den = sd7.fallback ? 32'(32'sd65536 - $signed({1'b0, model_alpha}))
                            : 32'($signed({2'b0, rq}) + 32'sd65536
                                  - $signed({1'b0, model_alpha}));
  assign nm  = num7[55] ? 56'(-num7) : 56'(num7);
  assign dm  = den[31] ? 31'(-den) : 31'(den);
  assign ov9 = n8[57:24] >= {2'b00, d8};

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      dv_in.valid <= 1'b0;
    end else if (en) begin
      v7 <= sq[SQ_CELLS].valid;
      v8 <= v7;

      sd7  <= sq[SQ_CELLS].side;
      num7 <= sq[SQ_CELLS].num;
      aq7  <= 45'(model_alpha * sq[SQ_CELLS].root);

      sd8   <= sd7;
      n8    <= {1'b0, nm, 1'b0} + {27'd0, dm};
      d8    <= {dm, 1'b0};
      dz8   <= (den == '0);
      neg8  <= num7[55] ^ den[31];
      nneg8 <= num7[55];

      dv_in <= '{valid: v8,
                 side: sd8,
                 neg: neg8,
                 dz: dz8,
                 ov: ov9,
                 num_neg: nneg8,
                 rem: ov9 ? 32'd0 : n8[55:24],
                 nlo: n8[23:0],
                 quo: 24'd0,
                 dd: d8};
    end
  end

  // Divider cell row.
  dv_t dv [DV_CELLS+1];
  assign dv[0] = dv_in;

  for (genvar i = 0; i < DV_CELLS; i++) begin : g_dv
    eucm_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (dv[i]),
      .q   (dv[i+1])
    );
  end

  // Result selection and output register.
  dv_t fin;
  logic signed [23:0] z;
  logic zsat;
  assign fin = dv[DV_CELLS];

  always_comb begin
    z    = '0;
    zsat = 1'b0;
    if (fin.dz) begin
      zsat = 1'b1;
      z    = fin.num_neg ? S24_MIN : S24_MAX;
    end else if (fin.ov) begin
      zsat = 1'b1;
      z    = fin.neg ? S24_MIN : S24_MAX;
    end else if (!fin.neg && fin.quo > 24'd8388607) begin
      zsat = 1'b1;
      z    = S24_MAX;
    end else if (fin.neg && fin.quo > 24'd8388608) begin
      zsat = 1'b1;
      z    = S24_MIN;
    end else if (fin.neg) begin
      z = 24'(-$signed({1'b0, fin.quo}));
    end else begin
      z = $signed(fin.quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_out       <= fin.side.last;
      distortion_off <= fin.side.off;
      if (fin.side.off) begin
        ray_x         <= '0;
        ray_y         <= '0;
        ray_z         <= '0;
        used_fallback <= 1'b0;
        saturated     <= 1'b0;
      end else begin
        ray_x         <= fin.side.x;
        ray_y         <= fin.side.y;
        ray_z         <= z;
        used_fallback <= fin.side.fallback;
        saturated     <= fin.side.sat | zsat;
      end
    end
  end

endmodule

// ===== hdl/eucm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// EUCM square-root cell
// One digit step of the integer square root; resolves one root bit per cell.
// ----------------------------------------------------------------------------
module eucm_sqrt_cell
  import eucm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  sq_t  d,
  output sq_t  q
);

  sq_t         nxt;
  logic [31:0] cur;
  logic [31:0] trial;

  always_comb begin
    nxt   = d;
    cur   = {d.rem, d.rad[55:54]};
    trial = {2'b00, d.root, 2'b01};
    nxt.rad = {d.rad[53:0], 2'b00};
    if (cur >= trial) begin
      nxt.rem  = 30'(cur - trial);
      nxt.root = {d.root[26:0], 1'b1};
    end else begin
      nxt.rem  = cur[29:0];
      nxt.root = {d.root[26:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hdl/eucm_div_cell.sv =====
// ----------------------------------------------------------------------------
// EUCM divider cell
// One restoring division step; resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
module eucm_div_cell
  import eucm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  dv_t  d,
  output dv_t  q
);

  dv_t         nxt;
  logic [32:0] cur;

  always_comb begin
    nxt = d;
    cur = {d.rem, d.nlo[23]};
    nxt.nlo = {d.nlo[22:0], 1'b0};
    if (cur >= {1'b0, d.dd}) begin
      nxt.rem = 32'(cur - {1'b0, d.dd});
      nxt.quo = {d.quo[22:0], 1'b1};
    end else begin
      nxt.rem = cur[31:0];
      nxt.quo = {d.quo[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule
